@@ sv/c2s_pkg.sv @@
// shared constants, tables and sideband types for the cartesian to spherical converter
package c2s_pkg;

  localparam int unsigned COORD_WIDTH   = 24;
  localparam int unsigned CORDIC_STAGES = 24;
  localparam int unsigned GUARD_BITS    = 8;
  localparam int unsigned ATAN_ENTRIES  = 40;
  localparam int unsigned ANGLE_W       = 32;

  // micro-rotations per vectoring pass
  localparam int unsigned PASS_STAGES =
    (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  // datapath width: coordinate, guard bits, cordic growth and the sqrt(3) head room
  localparam int unsigned DATA_W =
    (COORD_WIDTH + GUARD_BITS + 4 > 33) ? (COORD_WIDTH + GUARD_BITS + 4) : 33;

  // bits of a magnitude above the low 32-bit word
  localparam int unsigned HI_W = DATA_W - 32;

  // cycles from an accepted transaction to its result strobe
  localparam int unsigned LATENCY = 2 * PASS_STAGES + 6;

  // asymptotic cordic inverse gain, q32
  localparam logic [31:0] INV_GAIN = 32'd2608131496;

  localparam logic [ANGLE_W-1:0] ANGLE_PI = 32'h8000_0000;
  localparam logic signed [ANGLE_W-1:0] LAT_MAX = 32'sh4000_0000;
  localparam logic signed [ANGLE_W-1:0] LAT_MIN = -32'sh4000_0000;

  // atan(2^-i) in binary angle units, 2^31 = pi
  localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
  };

  // what travels alongside a vector through the pipeline
  typedef struct packed {
    logic                      skip;
    logic [ANGLE_W-1:0]        lon;
    logic signed [ANGLE_W-1:0] lat;
    logic signed [DATA_W-1:0]  z;
  } side_t;

endpackage

@@ sv/c2s_vector_pass.sv @@
// pipelined cordic vectoring pass, one micro-rotation per register stage
module c2s_vector_pass (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  logic signed [c2s_pkg::DATA_W-1:0]         x_i,
  input  logic signed [c2s_pkg::DATA_W-1:0]         y_i,
  input  logic [c2s_pkg::ANGLE_W-1:0]               ang_i,
  input  c2s_pkg::side_t                            side_i,
  output logic                                      valid_o,
  output logic signed [c2s_pkg::DATA_W-1:0]         x_o,
  output logic [c2s_pkg::ANGLE_W-1:0]               ang_o,
  output c2s_pkg::side_t                            side_o
);

  localparam int unsigned NS = c2s_pkg::PASS_STAGES;
  localparam int unsigned DW = c2s_pkg::DATA_W;
  localparam int unsigned AW = c2s_pkg::ANGLE_W;

  logic                 valid_q [NS];
  logic signed [DW-1:0] x_q     [NS];
  logic signed [DW-1:0] y_q     [NS];
  logic [AW-1:0]        ang_q   [NS];
  c2s_pkg::side_t       side_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                 va;
    logic signed [DW-1:0] xa;
    logic signed [DW-1:0] ya;
    logic [AW-1:0]        aa;
    c2s_pkg::side_t       sa;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] x_d;
    logic signed [DW-1:0] y_d;
    logic [AW-1:0]        ang_d;

    if (k == 0) begin : g_first
      assign va = valid_i;
      assign xa = x_i;
      assign ya = y_i;
      assign aa = ang_i;
      assign sa = side_i;
    end else begin : g_next
      assign va = valid_q[k-1];
      assign xa = x_q[k-1];
      assign ya = y_q[k-1];
      assign aa = ang_q[k-1];
      assign sa = side_q[k-1];
    end

    assign dx = ya >>> k;
    assign dy = xa >>> k;

    // rotate toward y = 0
    always_comb begin
      if (!ya[DW-1]) begin
        x_d   = xa + dx;
        y_d   = ya - dy;
        ang_d = aa + c2s_pkg::ATAN_TABLE[k];
      end else begin
        x_d   = xa - dx;
        y_d   = ya + dy;
        ang_d = aa - c2s_pkg::ATAN_TABLE[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= va;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[k]    <= x_d;
      y_q[k]    <= y_d;
      ang_q[k]  <= ang_d;
      side_q[k] <= sa;
    end
  end

  assign valid_o = valid_q[NS-1];
  assign x_o     = x_q[NS-1];
  assign ang_o   = ang_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

@@ sv/c2s_gain.sv @@
// two-stage cordic gain compensation, multiply then round half up
module c2s_gain (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [c2s_pkg::DATA_W-1:0]   v_i,
  input  c2s_pkg::side_t                      side_i,
  output logic                                valid_o,
  output logic [c2s_pkg::DATA_W-1:0]          mag_o,
  output c2s_pkg::side_t                      side_o
);

  localparam int unsigned DW = c2s_pkg::DATA_W;
  localparam int unsigned HW = c2s_pkg::HI_W;

  logic [DW-1:0]    u;
  logic [63:0]      p_lo_d;
  logic [HW+31:0]   p_hi_d;
  logic [63:0]      p_lo_q;
  logic [HW+31:0]   p_hi_q;
  logic             va_q;
  c2s_pkg::side_t   sa_q;
  logic [64:0]      rnd;
  logic [DW:0]      sum;
  logic [DW-1:0]    mag_d;
  logic             vb_q;
  logic [DW-1:0]    mag_q;
  c2s_pkg::side_t   sb_q;

  // negative magnitudes clamp to zero
  assign u      = v_i[DW-1] ? '0 : DW'(v_i);
  assign p_lo_d = 64'(u[31:0]) * 64'(c2s_pkg::INV_GAIN);
  assign p_hi_d = (HW+32)'(u[DW-1:32]) * (HW+32)'(c2s_pkg::INV_GAIN);

  assign rnd   = {1'b0, p_lo_q} + 65'h0_8000_0000;
  assign sum   = (DW+1)'(p_hi_q) + (DW+1)'(rnd[64:32]);
  assign mag_d = sum[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_lo_q <= p_lo_d;
    p_hi_q <= p_hi_d;
    sa_q   <= side_i;
    mag_q  <= mag_d;
    sb_q   <= sa_q;
  end

  assign valid_o = vb_q;
  assign mag_o   = mag_q;
  assign side_o  = sb_q;

endmodule

@@ sv/cartesian_to_spherical.sv @@
// top level: 3-d cartesian vector to radius, latitude and longitude
//
// fully pipelined converter: one transaction may start every cycle and busy is
// never raised. each result appears on the output ports for exactly one cycle,
// marked by done_o. the receiver cannot hold results off, so it must take every
// done_o strobe. the pipeline is made of the two chained cordic vectoring
// passes, one micro-rotation per register stage, plus an input stage, two
// 2-stage gain compensation units and the output register. angles are binary
// angles with 2^31 = pi; latitude lies in [-2^30, 2^30], longitude wraps over
// the full signed range. a zero vector gives all zeros.
module cartesian_to_spherical (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [c2s_pkg::COORD_WIDTH-1:0] x_in_i,
  input  logic signed [c2s_pkg::COORD_WIDTH-1:0] y_in_i,
  input  logic signed [c2s_pkg::COORD_WIDTH-1:0] z_in_i,
  output logic                                   done_o,
  output logic [c2s_pkg::COORD_WIDTH-1:0]        radius_o,
  output logic signed [c2s_pkg::ANGLE_W-1:0]     latitude_o,
  output logic signed [c2s_pkg::ANGLE_W-1:0]     longitude_o
);

  localparam int unsigned CW = c2s_pkg::COORD_WIDTH;
  localparam int unsigned DW = c2s_pkg::DATA_W;
  localparam int unsigned AW = c2s_pkg::ANGLE_W;
  localparam int unsigned GB = c2s_pkg::GUARD_BITS;

  // input stage
  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] ys;
  logic signed [DW-1:0] zs;
  logic                 in_valid_q;
  logic signed [DW-1:0] x1_q;
  logic signed [DW-1:0] y1_q;
  logic signed [DW-1:0] z1_q;
  logic [AW-1:0]        base_q;
  logic                 skip1_q;
  c2s_pkg::side_t       p1_side_in;

  // first pass and its gain
  logic                 p1_valid;
  logic signed [DW-1:0] p1_x;
  logic [AW-1:0]        p1_ang;
  c2s_pkg::side_t       p1_side;
  c2s_pkg::side_t       g1_side_in;
  logic                 g1_valid;
  logic [DW-1:0]        g1_mag;
  c2s_pkg::side_t       g1_side;

  // second pass and its gain
  logic [DW-1:0]        planar;
  logic                 skip2;
  c2s_pkg::side_t       p2_side_in;
  logic                 p2_valid;
  logic signed [DW-1:0] p2_x;
  logic [AW-1:0]        p2_ang;
  c2s_pkg::side_t       p2_side;
  logic signed [AW-1:0] lat_raw;
  logic signed [AW-1:0] lat_clamped;
  c2s_pkg::side_t       g2_side_in;
  logic                 g2_valid;
  logic [DW-1:0]        g2_mag;
  c2s_pkg::side_t       g2_side;

  // output stage
  logic [DW-1:0]        rad_g;
  logic [DW:0]          rad_sum;
  logic [DW:0]          rad_sh;
  logic                 rad_sat;
  logic [CW-1:0]        radius_d;
  logic                 done_q;
  logic [CW-1:0]        radius_q;
  logic signed [AW-1:0] lat_q;
  logic [AW-1:0]        lon_q;

  // the pipeline never stalls
  assign busy = 1'b0;

  // widen to the datapath and add guard bits
  assign xs = DW'(x_in_i) <<< GB;
  assign ys = DW'(y_in_i) <<< GB;
  assign zs = DW'(z_in_i) <<< GB;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  // left half plane: negate the vector and start the angle at pi
  always_ff @(posedge clk_i) begin
    if (xs[DW-1]) begin
      x1_q   <= -xs;
      y1_q   <= -ys;
      base_q <= c2s_pkg::ANGLE_PI;
    end else begin
      x1_q   <= xs;
      y1_q   <= ys;
      base_q <= '0;
    end
    z1_q    <= zs;
    skip1_q <= (x_in_i == '0) && (y_in_i == '0);
  end

  always_comb begin
    p1_side_in      = '0;
    p1_side_in.skip = skip1_q;
    p1_side_in.z    = z1_q;
  end

  // azimuth pass over (x, y)
  c2s_vector_pass u_pass_lon (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .x_i     (x1_q),
    .y_i     (y1_q),
    .ang_i   (base_q),
    .side_i  (p1_side_in),
    .valid_o (p1_valid),
    .x_o     (p1_x),
    .ang_o   (p1_ang),
    .side_o  (p1_side)
  );

  // x = y = 0 gives zero longitude
  always_comb begin
    g1_side_in     = p1_side;
    g1_side_in.lon = p1_side.skip ? '0 : p1_ang;
  end

  c2s_gain u_gain_planar (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p1_valid),
    .v_i     (p1_x),
    .side_i  (g1_side_in),
    .valid_o (g1_valid),
    .mag_o   (g1_mag),
    .side_o  (g1_side)
  );

  // planar radius feeds the elevation pass together with z
  assign planar = g1_side.skip ? '0 : g1_mag;
  assign skip2  = (planar == '0) && (g1_side.z == '0);

  always_comb begin
    p2_side_in      = '0;
    p2_side_in.skip = skip2;
    p2_side_in.lon  = g1_side.lon;
  end

  c2s_vector_pass u_pass_lat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g1_valid),
    .x_i     ($signed(planar)),
    .y_i     (g1_side.z),
    .ang_i   ('0),
    .side_i  (p2_side_in),
    .valid_o (p2_valid),
    .x_o     (p2_x),
    .ang_o   (p2_ang),
    .side_o  (p2_side)
  );

  // cordic residue may overshoot the poles slightly
  assign lat_raw = $signed(p2_ang);

  always_comb begin
    if (p2_side.skip) begin
      lat_clamped = '0;
    end else if (lat_raw > c2s_pkg::LAT_MAX) begin
      lat_clamped = c2s_pkg::LAT_MAX;
    end else if (lat_raw < c2s_pkg::LAT_MIN) begin
      lat_clamped = c2s_pkg::LAT_MIN;
    end else begin
      lat_clamped = lat_raw;
    end
  end

  always_comb begin
    g2_side_in     = p2_side;
    g2_side_in.lat = lat_clamped;
  end

  c2s_gain u_gain_radius (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p2_valid),
    .v_i     (p2_x),
    .side_i  (g2_side_in),
    .valid_o (g2_valid),
    .mag_o   (g2_mag),
    .side_o  (g2_side)
  );

  // drop guard bits rounding half up, then saturate to the coordinate range
  assign rad_g    = g2_side.skip ? '0 : g2_mag;
  assign rad_sum  = {1'b0, rad_g} + (DW+1)'(1 << (GB - 1));
  assign rad_sh   = rad_sum >> GB;
  assign rad_sat  = rad_sh > (DW+1)'({CW{1'b1}});
  assign radius_d = rad_sat ? {CW{1'b1}} : rad_sh[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= g2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    radius_q <= radius_d;
    lat_q    <= g2_side.lat;
    lon_q    <= g2_side.lon;
  end

  assign done_o      = done_q;
  assign radius_o    = radius_q;
  assign latitude_o  = lat_q;
  assign longitude_o = $signed(lon_q);

endmodule

@@ sv/c2s_checker.sv @@
// port-level checker for the cartesian to spherical converter, with its bind
module c2s_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   start,
  input logic                                   busy,
  input logic signed [c2s_pkg::COORD_WIDTH-1:0] x_in_i,
  input logic signed [c2s_pkg::COORD_WIDTH-1:0] y_in_i,
  input logic signed [c2s_pkg::COORD_WIDTH-1:0] z_in_i,
  input logic                                   done_o,
  input logic [c2s_pkg::COORD_WIDTH-1:0]        radius_o,
  input logic signed [c2s_pkg::ANGLE_W-1:0]     latitude_o,
  input logic signed [c2s_pkg::ANGLE_W-1:0]     longitude_o
);

  // a streaming block never pushes back
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  // every result strobe matches a transaction accepted a fixed latency earlier
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, c2s_pkg::LATENCY))
    else $error("result without a matching transaction");

  // latitude stays between the poles
  a_lat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (latitude_o <= c2s_pkg::LAT_MAX) && (latitude_o >= c2s_pkg::LAT_MIN))
    else $error("latitude beyond a pole");

  // zero vector maps to all-zero outputs
  a_zero_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(x_in_i == '0, c2s_pkg::LATENCY) &&
    $past(y_in_i == '0, c2s_pkg::LATENCY) && $past(z_in_i == '0, c2s_pkg::LATENCY)
    |-> (radius_o == '0) && (latitude_o == '0) && (longitude_o == '0))
    else $error("zero vector gave nonzero result");

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (.*);
